// ===== hdl/lsl_pkg.sv =====
// Package for the logarithmic soft limiter: request types, register indexes,
// the ln 2 constant and the elaboration-time log2 table function.
// No dependencies.
package lsl_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ROM_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_C   = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd32768;
  localparam logic [31:0] GAIN_B_RST    = 32'd65536;
  localparam logic [31:0] SCALE_C_RST   = 32'd16777216;

  // ln 2 in Q.28
  localparam logic [27:0] LN2_Q28 = 28'd186065280;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
  } out_t;

  // Per-request side data that rides along the pipeline
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                neg;
    logic                lim;
    logic                blk;
  } side_t;

  // log2(1 + k / 2^ltb) in Q.30 by repeated squaring
  function automatic logic [ROM_W-1:0] rom_entry(input int unsigned ltb, input int unsigned k);
    logic [63:0]      m;
    logic [ROM_W-1:0] res;
    m   = ((64'd1 << ltb) + 64'(k)) << (30 - ltb);
    res = '0;
    if (m >= (64'd2 << 30)) begin
      res[30] = 1'b1;
      m = m >> 1;
    end
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        res[b] = 1'b1;
        m = m >> 1;
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/log_soft_limiter.sv =====
// Logarithmic soft limiter: top level, a 13-stage pipelined fixed-point datapath.
// Depends on lsl_pkg.
// Accepts one Q7.16 sample per clock unless stalled; it runs through 12 datapath
// stages and the output register. Samples below the threshold pass unchanged;
// others become sign * (thres + (1-thres) * ln(1 + (|x|-thres)*b) * c), saturated,
// using a 2^LOG_TABLE_BITS+1 entry log2 table with linear interpolation. The whole
// pipeline advances as one; a stall on the output freezes every stage and raises
// in_stall_o in the same cycle. Registers (threshold, gain_b, scale_c) are written
// through the config port, which is always ready; write them only while idle.
module log_soft_limiter
  import lsl_pkg::*;
#(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LTB   = LOG_TABLE_BITS;
  localparam int unsigned ROM_N = (1 << LTB) + 1;
  localparam int unsigned NS    = 12;

  // config registers
  logic [15:0] thr_q;
  logic [31:0] gain_b_q;
  logic [31:0] scale_c_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESHOLD_RST;
      gain_b_q  <= GAIN_B_RST;
      scale_c_q <= SCALE_C_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_THRESHOLD: thr_q     <= cfg_data_i[15:0];
        CFG_GAIN_B:    gain_b_q  <= cfg_data_i;
        CFG_SCALE_C:   scale_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // log2 table
  logic [ROM_W-1:0] rom [ROM_N];
  for (genvar k = 0; k < ROM_N; k++) begin : g_rom
    assign rom[k] = rom_entry(LTB, k);
  end

  // pipeline control
  logic       adv;
  logic [NS-1:0] vld_q;
  logic       out_valid_q;
  side_t      side_q [NS];
  side_t      side_d;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NS-2:0], in_valid_i};
      out_valid_q <= vld_q[NS-1];
    end
  end

  // stage 1: magnitude and threshold compare
  logic [SAMPLE_W-1:0] s_in, mag, thr_ext, d1_d;
  assign s_in    = in_data_i.sample_in;
  assign thr_ext = {8'd0, thr_q};
  assign mag     = s_in[SAMPLE_W-1] ? (24'd0 - s_in) : s_in;
  assign d1_d    = mag - thr_ext;

  always_comb begin
    side_d.sample = s_in;
    side_d.neg    = s_in[SAMPLE_W-1];
    side_d.lim    = (mag >= thr_ext);
    side_d.blk    = in_data_i.block_end_in;
  end

  logic [SAMPLE_W-1:0] d1_q;
  // stage 2
  logic [55:0] prod2, v2_q;
  // stage 3
  logic [4:0]  e3_d, e3_q;
  logic [55:0] v3_q;
  // stage 4
  logic [55:0]     w4;
  logic [4:0]      sh4;
  logic [LTB-1:0]  idx4_q;
  logic [15:0]     r4_q;
  logic [4:0]      e4_q;
  // stage 5
  logic [LTB:0]      idx_hi;
  logic [ROM_W-1:0]  lo5_q, hi5_q;
  logic [15:0]       r5_q;
  logic [4:0]        e5_q;
  // stage 6
  logic [ROM_W-1:0]  diff6;
  logic [46:0]       prd6_q;
  logic [ROM_W-1:0]  lo6_q;
  logic [4:0]        e6_q;
  // stage 7
  logic [ROM_W-1:0]  l27_q;
  logic [4:0]        e7_q;
  // stage 8
  logic [58:0] pa8_q;
  logic [32:0] pe8_q;
  // stage 9
  logic [63:0] sum9;
  logic [34:0] ln9_q;
  // stage 10
  logic [16:0] om10;
  logic [51:0] mt10_q;
  // stage 11
  logic [52:0] sum11;
  logic [20:0] t11_q;
  // stage 12
  logic [52:0] mu12_q;
  // output
  logic [53:0] sum13;
  logic [30:0] y13;
  logic [SAMPLE_W-1:0] res13;
  out_t        out_d, out_q;

  assign prod2 = d1_q * gain_b_q;

  always_comb begin
    e3_d = '0;
    for (int j = 0; j < 24; j++) begin
      if (v2_q[32 + j]) e3_d = 5'(j);
    end
  end

  assign sh4    = 5'd23 - e3_q;
  assign w4     = v3_q << sh4;
  assign idx_hi = {1'b0, idx4_q} + {{LTB{1'b0}}, 1'b1};
  assign diff6  = hi5_q - lo5_q;
  assign sum9   = 64'({pe8_q, 30'd0}) + 64'(pa8_q) + 64'(1 << 27);
  assign om10   = 17'd65536 - 17'(thr_q);
  assign sum11  = 53'(mt10_q) + 53'(1 << 29);
  assign sum13  = 54'(mu12_q) + 54'(1 << 23);
  assign y13    = 31'(thr_q) + 31'(sum13[53:24]);

  always_comb begin
    res13 = side_q[NS-1].sample;
    if (side_q[NS-1].lim) begin
      if (side_q[NS-1].neg) begin
        res13 = (y13 > 31'd8388608) ? 24'h800000 : (24'd0 - y13[23:0]);
      end else begin
        res13 = (y13 > 31'd8388607) ? 24'h7FFFFF : y13[23:0];
      end
    end
    out_d.sample_out    = res13;
    out_d.block_end_out = side_q[NS-1].blk;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int k = 1; k < NS; k++) side_q[k] <= side_q[k-1];
      d1_q   <= d1_d;
      v2_q   <= (56'd1 << 32) + prod2;
      e3_q   <= e3_d;
      v3_q   <= v2_q;
      idx4_q <= w4[54 -: LTB];
      r4_q   <= w4[54-LTB -: 16];
      e4_q   <= e3_q;
      lo5_q  <= rom[{1'b0, idx4_q}];
      hi5_q  <= rom[idx_hi];
      r5_q   <= r4_q;
      e5_q   <= e4_q;
      prd6_q <= diff6 * r5_q;
      lo6_q  <= lo5_q;
      e6_q   <= e5_q;
      l27_q  <= lo6_q + prd6_q[46:16];
      e7_q   <= e6_q;
      pa8_q  <= l27_q * LN2_Q28;
      pe8_q  <= e7_q * LN2_Q28;
      ln9_q  <= sum9[62:28];
      mt10_q <= ln9_q * om10;
      t11_q  <= sum11[50:30];
      mu12_q <= t11_q * scale_c_q;
      out_q  <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
